[rtl/core/life_grid_generation_step_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the life grid generation step block
// Each macro clocks on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg
// Types and fixed constants shared by the life grid generation step modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

    localparam int OP_W  = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;
    localparam int CFG_W = 7;
    // One more bit than a size, so that a sweep can count to the size itself.
    localparam int SEQ_W = CFG_W + 1;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    // Birth needs exactly three live cells in the window; a live cell, which
    // counts itself, survives with three or four.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd4;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_FILL    = 2'd2,
        OP_ADVANCE = 2'd3
    } lgs_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_FILL,
        ST_FILL_LAST,
        ST_ADV_ISSUE,
        ST_ADV_ARRIVE,
        ST_ADV_TAIL,
        ST_ADV_WRITE,
        ST_FINAL_RD,
        ST_FINAL_DATA,
        ST_FINISH
    } lgs_state_t;

endpackage

`default_nettype wire

[rtl/core/lgs_row_update.sv]
// ----------------------------------------------------------------------------
// lgs_row_update
// Computes the next generation of one grid row from the old row and its two
// wrapped neighbor rows. Columns beyond the active width keep their value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_row_update #(
    parameter int MAX_COLUMNS = 64
) (
    input  wire logic [MAX_COLUMNS-1:0]       above,
    input  wire logic [MAX_COLUMNS-1:0]       mid,
    input  wire logic [MAX_COLUMNS-1:0]       below,
    input  wire logic [MAX_COLUMNS-1:0]       col_active,
    input  wire logic [lgs_pkg::CFG_W-1:0]    cols_eff,
    output logic      [MAX_COLUMNS-1:0]       next_row
);

    localparam int ColAw = $clog2(MAX_COLUMNS);
    localparam int CfgW  = lgs_pkg::CFG_W;

    logic [ColAw-1:0] last_idx;
    logic             above_last;
    logic             mid_last;
    logic             below_last;

    assign last_idx   = ColAw'(cols_eff - CfgW'(1));
    assign above_last = above[last_idx];
    assign mid_last   = mid[last_idx];
    assign below_last = below[last_idx];

    for (genvar gc = 0; gc < MAX_COLUMNS; gc++) begin : g_col
        logic [2:0] left_bits;
        logic [2:0] right_bits;
        logic [3:0] live_count;
        logic       alive;

        if (gc == 0) begin : g_left_wrap
            assign left_bits = {above_last, mid_last, below_last};
        end else begin : g_left
            assign left_bits = {above[gc-1], mid[gc-1], below[gc-1]};
        end

        if (gc == MAX_COLUMNS - 1) begin : g_right_wrap
            assign right_bits = {above[0], mid[0], below[0]};
        end else begin : g_right
            // The last active column wraps around to column zero.
            assign right_bits = (32'(cols_eff) == gc + 1)
                ? {above[0], mid[0], below[0]}
                : {above[gc+1], mid[gc+1], below[gc+1]};
        end

        assign live_count = {3'b000, left_bits[2]} + {3'b000, left_bits[1]}
                          + {3'b000, left_bits[0]} + {3'b000, above[gc]}
                          + {3'b000, mid[gc]} + {3'b000, below[gc]}
                          + {3'b000, right_bits[2]} + {3'b000, right_bits[1]}
                          + {3'b000, right_bits[0]};

        assign alive = (live_count == lgs_pkg::BIRTH_COUNT)
                    || (mid[gc] && (live_count == lgs_pkg::SURVIVE_COUNT));

        assign next_row[gc] = col_active[gc] ? alive : mid[gc];
    end

endmodule

`default_nettype wire

[rtl/core/life_grid_generation_step.sv]
// One item is in work at a time; the next is taken the cycle after its result
// is registered. A generation sweeps one row per cycle. After reset, a clearing
// pass zeroes all MAX_ROWS grid rows; no input is taken during it.
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Toroidal B3/S23 life grid held in a row-wide synchronous memory, with cell
// write, cell read, fill and generation operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "life_grid_generation_step_assert.svh"

module life_grid_generation_step #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lgs_pkg::OP_W-1:0]          operation,
    input  wire logic [lgs_pkg::ROW_W-1:0]         row,
    input  wire logic [lgs_pkg::COL_W-1:0]         column,
    input  wire logic                              cell_value,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   cell_state,
    output logic                                   address_error,

    input  wire logic                              cfg_we,
    input  wire logic [lgs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lgs_pkg::CFG_W-1:0]         cfg_data
);

    localparam int RowAw = $clog2(MAX_ROWS);
    localparam int ColAw = $clog2(MAX_COLUMNS);
    localparam int CfgW  = lgs_pkg::CFG_W;
    localparam int SeqW  = lgs_pkg::SEQ_W;

    lgs_pkg::lgs_state_t state_reg;
    lgs_pkg::lgs_state_t state_next;

    logic [CfgW-1:0]        row_count_reg;
    logic [CfgW-1:0]        column_count_reg;
    logic [CfgW-1:0]        rows_eff;
    logic [CfgW-1:0]        cols_eff;

    lgs_pkg::lgs_op_t       op_reg;
    logic [lgs_pkg::ROW_W-1:0] row_reg;
    logic [lgs_pkg::COL_W-1:0] col_reg;
    logic                   val_reg;
    logic                   bad_reg;
    logic                   bad_in;
    logic                   accept;
    logic                   out_free;

    logic [SeqW-1:0]        sweep_reg;
    logic [SeqW-1:0]        rows_seq;
    logic [RowAw-1:0]       clr_addr_reg;

    logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
    logic [MAX_COLUMNS-1:0] rdata_reg;
    logic                   rd_en;
    logic [RowAw-1:0]       rd_addr;
    logic                   wr_en;
    logic [RowAw-1:0]       wr_addr;
    logic [MAX_COLUMNS-1:0] wr_data;

    logic                   arr_valid_reg;
    logic [SeqW-1:0]        arr_seq_reg;
    logic                   adv_arrival;
    logic                   cmp_from_arrival;

    logic [MAX_COLUMNS-1:0] win_a_reg;
    logic [MAX_COLUMNS-1:0] win_b_reg;
    logic [MAX_COLUMNS-1:0] row0_reg;

    logic                   cmp_valid_reg;
    logic [RowAw-1:0]       cmp_row_reg;
    logic [MAX_COLUMNS-1:0] cmp_above_reg;
    logic [MAX_COLUMNS-1:0] cmp_mid_reg;
    logic [MAX_COLUMNS-1:0] cmp_below_reg;

    logic [MAX_COLUMNS-1:0] col_active;
    logic [MAX_COLUMNS-1:0] upd_row;
    logic [MAX_COLUMNS-1:0] fill_row;
    logic [MAX_COLUMNS-1:0] cell_row;
    logic [ColAw-1:0]       col_idx;

    logic                   res_cell_reg;
    logic                   out_valid_reg;
    logic                   cell_state_reg;
    logic                   address_error_reg;

    // Size registers of zero act as one; sizes above the grid act as the grid.
    assign rows_eff = (row_count_reg == '0) ? CfgW'(1)
                    : ((32'(row_count_reg) > MAX_ROWS) ? CfgW'(MAX_ROWS) : row_count_reg);
    assign cols_eff = (column_count_reg == '0) ? CfgW'(1)
                    : ((32'(column_count_reg) > MAX_COLUMNS)
                       ? CfgW'(MAX_COLUMNS) : column_count_reg);

    assign rows_seq = {1'b0, rows_eff};
    assign bad_in   = ({1'b0, row} >= rows_eff) || ({1'b0, column} >= cols_eff);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign col_idx  = ColAw'(col_reg);

    for (genvar gc = 0; gc < MAX_COLUMNS; gc++) begin : g_active
        assign col_active[gc] = 32'(cols_eff) > gc;
    end

    assign fill_row = (rdata_reg & ~col_active) | (val_reg ? col_active : '0);

    always_comb
    begin
        cell_row          = rdata_reg;
        cell_row[col_idx] = val_reg;
    end

    assign adv_arrival      = arr_valid_reg && (op_reg == lgs_pkg::OP_ADVANCE);
    assign cmp_from_arrival = adv_arrival && (arr_seq_reg >= SeqW'(2));

    lgs_row_update #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_row_update (
        .above      (cmp_above_reg),
        .mid        (cmp_mid_reg),
        .below      (cmp_below_reg),
        .col_active (col_active),
        .cols_eff   (cols_eff),
        .next_row   (upd_row)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lgs_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == RowAw'(MAX_ROWS - 1))
                    state_next = lgs_pkg::ST_IDLE;
            end
            lgs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (lgs_pkg::lgs_op_t'(operation))
                        lgs_pkg::OP_WRITE:
                            state_next = bad_in ? lgs_pkg::ST_FINISH : lgs_pkg::ST_CELL_RD;
                        lgs_pkg::OP_READ:
                            state_next = bad_in ? lgs_pkg::ST_FINISH : lgs_pkg::ST_FINAL_RD;
                        lgs_pkg::OP_FILL:
                            state_next = lgs_pkg::ST_FILL;
                        lgs_pkg::OP_ADVANCE:
                            state_next = lgs_pkg::ST_ADV_ISSUE;
                        default:
                            state_next = lgs_pkg::ST_IDLE;
                    endcase
                end
            end
            lgs_pkg::ST_CELL_RD:    state_next = lgs_pkg::ST_CELL_WR;
            lgs_pkg::ST_CELL_WR:    state_next = lgs_pkg::ST_FINISH;
            lgs_pkg::ST_FILL:
            begin
                if (sweep_reg == rows_seq - SeqW'(1))
                    state_next = lgs_pkg::ST_FILL_LAST;
            end
            lgs_pkg::ST_FILL_LAST:  state_next = lgs_pkg::ST_FINISH;
            lgs_pkg::ST_ADV_ISSUE:
            begin
                if (sweep_reg == rows_seq)
                    state_next = lgs_pkg::ST_ADV_ARRIVE;
            end
            lgs_pkg::ST_ADV_ARRIVE: state_next = lgs_pkg::ST_ADV_TAIL;
            lgs_pkg::ST_ADV_TAIL:   state_next = lgs_pkg::ST_ADV_WRITE;
            lgs_pkg::ST_ADV_WRITE:
                state_next = bad_reg ? lgs_pkg::ST_FINISH : lgs_pkg::ST_FINAL_RD;
            lgs_pkg::ST_FINAL_RD:   state_next = lgs_pkg::ST_FINAL_DATA;
            lgs_pkg::ST_FINAL_DATA: state_next = lgs_pkg::ST_FINISH;
            lgs_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = lgs_pkg::ST_IDLE;
            end
            default:                state_next = lgs_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: memory port controls
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall = (state_reg != lgs_pkg::ST_IDLE);
        rd_en    = 1'b0;
        rd_addr  = RowAw'(row_reg);
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;

        // Write-back of rows returning from a fill or generation sweep.
        if (arr_valid_reg && (op_reg == lgs_pkg::OP_FILL))
        begin
            wr_en   = 1'b1;
            wr_addr = RowAw'(arr_seq_reg);
            wr_data = fill_row;
        end
        if (cmp_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = cmp_row_reg;
            wr_data = upd_row;
        end

        unique case (state_reg)
            lgs_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            lgs_pkg::ST_CELL_RD:
                rd_en = 1'b1;
            lgs_pkg::ST_CELL_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = RowAw'(row_reg);
                wr_data = cell_row;
            end
            lgs_pkg::ST_FILL:
            begin
                rd_en   = 1'b1;
                rd_addr = RowAw'(sweep_reg);
            end
            lgs_pkg::ST_ADV_ISSUE:
            begin
                // The sweep starts with the last row, which sits above row zero.
                rd_en   = 1'b1;
                rd_addr = (sweep_reg == '0) ? RowAw'(rows_eff - CfgW'(1))
                                            : RowAw'(sweep_reg - SeqW'(1));
            end
            lgs_pkg::ST_FINAL_RD:
                rd_en = 1'b1;
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lgs_pkg::ST_CLEAR;
            row_count_reg    <= lgs_pkg::CFG_SIZE_RESET;
            column_count_reg <= lgs_pkg::CFG_SIZE_RESET;
            sweep_reg        <= '0;
            clr_addr_reg     <= '0;
            arr_valid_reg    <= 1'b0;
            cmp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    lgs_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    lgs_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
                sweep_reg <= '0;
            else if ((state_reg == lgs_pkg::ST_FILL) || (state_reg == lgs_pkg::ST_ADV_ISSUE))
                sweep_reg <= sweep_reg + SeqW'(1);

            if (state_reg == lgs_pkg::ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + RowAw'(1);

            arr_valid_reg <= rd_en && ((state_reg == lgs_pkg::ST_FILL)
                                    || (state_reg == lgs_pkg::ST_ADV_ISSUE));
            cmp_valid_reg <= cmp_from_arrival || (state_reg == lgs_pkg::ST_ADV_TAIL);

            if ((state_reg == lgs_pkg::ST_FINISH) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= lgs_pkg::lgs_op_t'(operation);
            row_reg      <= row;
            col_reg      <= column;
            val_reg      <= cell_value;
            bad_reg      <= bad_in;
            res_cell_reg <= !bad_in && cell_value;
        end
        else if (state_reg == lgs_pkg::ST_FINAL_DATA)
        begin
            res_cell_reg <= rdata_reg[col_idx];
        end

        arr_seq_reg <= sweep_reg;

        // Three-row window of old rows; row zero is kept for the last row.
        if (adv_arrival)
        begin
            win_a_reg <= win_b_reg;
            win_b_reg <= rdata_reg;
            if (arr_seq_reg == SeqW'(1))
                row0_reg <= rdata_reg;
        end

        if (cmp_from_arrival)
        begin
            cmp_above_reg <= win_a_reg;
            cmp_mid_reg   <= win_b_reg;
            cmp_below_reg <= rdata_reg;
            cmp_row_reg   <= RowAw'(arr_seq_reg - SeqW'(2));
        end
        else if (state_reg == lgs_pkg::ST_ADV_TAIL)
        begin
            cmp_above_reg <= win_a_reg;
            cmp_mid_reg   <= win_b_reg;
            cmp_below_reg <= row0_reg;
            cmp_row_reg   <= RowAw'(rows_eff - CfgW'(1));
        end

        if ((state_reg == lgs_pkg::ST_FINISH) && out_free)
        begin
            cell_state_reg    <= res_cell_reg;
            address_error_reg <= bad_reg;
        end
    end

    // ------------------------------------------------------------------
    // Grid memory: one row per entry, registered read data.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign cell_state    = cell_state_reg;
    assign address_error = address_error_reg;

    `LGS_ASSERT_IMP(a_no_same_row_rw, wr_en && rd_en, wr_addr != rd_addr,
        "grid row read and written in the same cycle")
    `LGS_ASSERT_NEXT(a_finish_loads_result, (state_reg == lgs_pkg::ST_FINISH) && out_free,
        out_valid_reg, "finished item did not reach the output register")
    `LGS_ASSERT_IMP(a_error_reads_dead, out_valid_reg && address_error_reg, !cell_state_reg,
        "bad address result shows a live cell")
    `LGS_ASSERT_IMP(a_update_only_in_advance, cmp_valid_reg,
        op_reg == lgs_pkg::OP_ADVANCE, "row update outside a generation")

endmodule

`default_nettype wire
